[src/dcmq_pkg.sv]
`timescale 1ns / 1ps

package dcmq_pkg;

	// Width of a matrix entry and of a quaternion component
	localparam int unsigned CW = 16;

	typedef logic signed [CW-1:0] coef_t;

	// Sideband that rides along the divider: sign of each component and the flag
	typedef struct packed {
		logic       inv;
		logic [3:0] neg;
	} div_side_t;

endpackage

[src/dcmq_sqrt.sv]
`timescale 1ns / 1ps

module dcmq_sqrt #(
	parameter int NW = 40,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [NW-1:0]   rad,
	input  logic [SW-1:0]   in_side,
	output logic            out_vld,
	output logic [NW/2-1:0] root,
	output logic [SW-1:0]   out_side
);
	localparam int RW = NW / 2;

	logic          vld_s  [RW];
	logic [NW-1:0] rad_s  [RW];
	logic [RW+1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [SW-1:0] side_s [RW];

	// One result bit per stage: bring down two radicand bits, try 4P+1
	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic          vld_i;
		logic [NW-1:0] rad_i;
		logic [RW+1:0] rem_i;
		logic [RW-1:0] root_i;
		logic [SW-1:0] side_i;
		logic [RW+3:0] trial;
		logic [RW+3:0] test;
		logic [RW+3:0] diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_i  = in_vld;
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = {rem_i, rad_i[NW-1 -: 2]};
		assign test  = {2'b00, root_i, 2'b01};
		assign diff  = trial - test;
		assign ge    = (trial >= test);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k]  <= rad_i << 2;
			rem_s[k]  <= ge ? diff[RW+1:0] : trial[RW+1:0];
			root_s[k] <= {root_i[RW-2:0], ge};
			side_s[k] <= side_i;
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign root     = root_s[RW-1];
	assign out_side = side_s[RW-1];

endmodule

[src/dcmq_div.sv]
`timescale 1ns / 1ps

module dcmq_div #(
	parameter int MW = 18,
	parameter int F  = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	input  logic [3:0][MW-1:0]     mag,
	input  logic [MW:0]            den,
	input  dcmq_pkg::div_side_t    in_side,
	output logic                   out_vld,
	output logic [3:0][F:0]        quo,
	output dcmq_pkg::div_side_t    out_side
);
	import dcmq_pkg::*;

	localparam int DW   = MW + 1;
	localparam int QW   = F + 1;
	localparam int NUMW = MW + F + 1;

	// Rounded numerator: mag * 2^F + floor(den / 2)
	logic                 vld_s0;
	logic [3:0][NUMW-1:0] num_s0;
	logic [DW-1:0]        den_s0;
	div_side_t            side_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			num_s0[l] <= {1'b0, mag[l], {F{1'b0}}} + NUMW'(den[DW-1:1]);
		end
		den_s0  <= den;
		side_s0 <= in_side;
	end

	logic               vld_s  [QW];
	logic [3:0][DW-1:0] rem_s  [QW];
	logic [3:0][QW-1:0] lo_s   [QW];
	logic [3:0][QW-1:0] quo_s  [QW];
	logic [DW-1:0]      den_s  [QW];
	div_side_t          side_s [QW];

	// Restoring division, one quotient bit per stage in all four lanes
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic               vld_i;
		logic [3:0][DW-1:0] rem_i;
		logic [3:0][QW-1:0] lo_i;
		logic [3:0][QW-1:0] quo_i;
		logic [DW-1:0]      den_i;
		div_side_t          side_i;

		if (k == 0) begin : g_first
			assign vld_i  = vld_s0;
			assign den_i  = den_s0;
			assign side_i = side_s0;
			for (genvar l = 0; l < 4; l++) begin : g_lane
				assign rem_i[l] = DW'(num_s0[l][NUMW-1:QW]);
				assign lo_i[l]  = num_s0[l][QW-1:0];
				assign quo_i[l] = '0;
			end
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign lo_i   = lo_s[k-1];
			assign quo_i  = quo_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			logic [DW:0] trial;
			logic [DW:0] diff;
			logic        ge;
			for (int l = 0; l < 4; l++) begin
				trial       = {rem_i[l], lo_i[l][QW-1]};
				diff        = trial - {1'b0, den_i};
				ge          = (trial >= {1'b0, den_i});
				rem_s[k][l] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				lo_s[k][l]  <= lo_i[l] << 1;
				quo_s[k][l] <= {quo_i[l][QW-2:0], ge};
			end
			den_s[k]  <= den_i;
			side_s[k] <= side_i;
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign quo      = quo_s[QW-1];
	assign out_side = side_s[QW-1];

endmodule

[src/dcm_to_quaternion.sv]
`timescale 1ns / 1ps

// Direction cosine matrix to unit quaternion, Shepperd's method, fixed point
// with FRAC_BITS fraction bits. Pulse start with the nine entries valid; busy
// is always low, so a new matrix may be given on every clock. The result shows
// on qx, qy, qz, qw and invalid for exactly one cycle, marked by done. It is
// registered through the estimate, pivot, square and norm stages, the
// bit-per-stage square root of the squared norm, the rounding stage and the
// bit-per-stage divider that scales each component, and the output register.
// The receiver cannot hold a result off; it must sample done every cycle. When
// the largest of the four estimates is not positive, the components come out
// zero and invalid is set.
module dcm_to_quaternion #(
	parameter int FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  dcmq_pkg::coef_t c00,
	input  dcmq_pkg::coef_t c01,
	input  dcmq_pkg::coef_t c02,
	input  dcmq_pkg::coef_t c10,
	input  dcmq_pkg::coef_t c11,
	input  dcmq_pkg::coef_t c12,
	input  dcmq_pkg::coef_t c20,
	input  dcmq_pkg::coef_t c21,
	input  dcmq_pkg::coef_t c22,
	output logic            done,
	output dcmq_pkg::coef_t qx,
	output dcmq_pkg::coef_t qy,
	output dcmq_pkg::coef_t qz,
	output dcmq_pkg::coef_t qw,
	output logic            invalid
);
	import dcmq_pkg::*;

	// Estimate width: holds 2^F plus three entries
	localparam int EW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
	localparam int MW = EW - 1;          // component magnitude
	localparam int NW = 2 * MW + 2;      // sum of four squares
	localparam int RW = MW + 1;          // norm
	localparam int QW = FRAC_BITS + 1;   // scaled component, at most 2^F
	localparam int OW = 17;              // off-diagonal sum or difference
	localparam int SW = 4 * MW + 5;

	localparam logic signed [EW-1:0] ONE =
		{{(EW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	// Component and pivot order: x, y, z, w
	localparam logic [1:0] PIV_X = 2'd0;
	localparam logic [1:0] PIV_Y = 2'd1;
	localparam logic [1:0] PIV_Z = 2'd2;
	localparam logic [1:0] PIV_W = 2'd3;

	// Off-diagonal terms
	localparam int OD_12M21 = 0;
	localparam int OD_20M02 = 1;
	localparam int OD_01M10 = 2;
	localparam int OD_01P10 = 3;
	localparam int OD_20P02 = 4;
	localparam int OD_12P21 = 5;

	// Pure pipeline with no stall: never refuse a transfer
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// Stage 1: four estimates of 4*q^2 and the six off-diagonal terms
	// ---------------------------------------------------------------
	logic                   vld_s1;
	logic signed [EW-1:0]   est_s1 [4];
	logic signed [OW-1:0]   od_s1  [6];

	always_ff @(posedge clk) begin
		est_s1[0] <= ONE + EW'(c00) - EW'(c11) - EW'(c22);
		est_s1[1] <= ONE + EW'(c11) - EW'(c00) - EW'(c22);
		est_s1[2] <= ONE + EW'(c22) - EW'(c00) - EW'(c11);
		est_s1[3] <= ONE + EW'(c00) + EW'(c11) + EW'(c22);
		od_s1[OD_12M21] <= OW'(c12) - OW'(c21);
		od_s1[OD_20M02] <= OW'(c20) - OW'(c02);
		od_s1[OD_01M10] <= OW'(c01) - OW'(c10);
		od_s1[OD_01P10] <= OW'(c01) + OW'(c10);
		od_s1[OD_20P02] <= OW'(c20) + OW'(c02);
		od_s1[OD_12P21] <= OW'(c12) + OW'(c21);
	end

	// ---------------------------------------------------------------
	// Stage 2: pick the pivot (lowest index on ties), form the vector
	// ---------------------------------------------------------------
	logic [1:0]           piv_a;
	logic [1:0]           piv_b;
	logic [1:0]           piv;
	logic signed [EW-1:0] pmax;
	logic signed [EW-1:0] odx [6];
	logic signed [EW-1:0] v_c [4];

	always_comb begin
		piv_a = (est_s1[1] > est_s1[0]) ? PIV_Y : PIV_X;
		piv_b = (est_s1[3] > est_s1[2]) ? PIV_W : PIV_Z;
		piv   = (est_s1[piv_b] > est_s1[piv_a]) ? piv_b : piv_a;
		pmax  = est_s1[piv];
		for (int j = 0; j < 6; j++) begin
			odx[j] = EW'(od_s1[j]);
		end
		unique case (piv)
			PIV_X: begin
				v_c[0] = pmax;
				v_c[1] = odx[OD_01P10];
				v_c[2] = odx[OD_20P02];
				v_c[3] = odx[OD_12M21];
			end
			PIV_Y: begin
				v_c[0] = odx[OD_01P10];
				v_c[1] = pmax;
				v_c[2] = odx[OD_12P21];
				v_c[3] = odx[OD_20M02];
			end
			PIV_Z: begin
				v_c[0] = odx[OD_20P02];
				v_c[1] = odx[OD_12P21];
				v_c[2] = pmax;
				v_c[3] = odx[OD_01M10];
			end
			default: begin
				v_c[0] = odx[OD_12M21];
				v_c[1] = odx[OD_20M02];
				v_c[2] = odx[OD_01M10];
				v_c[3] = pmax;
			end
		endcase
	end

	logic                 vld_s2;
	logic                 inv_s2;
	logic signed [EW-1:0] v_s2 [4];

	always_ff @(posedge clk) begin
		inv_s2 <= pmax[EW-1] || (pmax == '0);
		for (int i = 0; i < 4; i++) begin
			v_s2[i] <= v_c[i];
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: magnitudes and squares
	// ---------------------------------------------------------------
	logic [3:0][MW-1:0] mag_c;

	always_comb begin
		logic signed [EW-1:0] vn;
		for (int i = 0; i < 4; i++) begin
			vn       = -v_s2[i];
			mag_c[i] = v_s2[i][EW-1] ? vn[MW-1:0] : v_s2[i][MW-1:0];
		end
	end

	logic               vld_s3;
	logic               inv_s3;
	logic [3:0]         neg_s3;
	logic [3:0][MW-1:0] mag_s3;
	logic [2*MW-1:0]    sq_s3 [4];

	always_ff @(posedge clk) begin
		inv_s3 <= inv_s2;
		mag_s3 <= mag_c;
		for (int i = 0; i < 4; i++) begin
			neg_s3[i] <= v_s2[i][EW-1];
			sq_s3[i]  <= mag_c[i] * mag_c[i];
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: squared norm
	// ---------------------------------------------------------------
	logic               vld_s4;
	logic               inv_s4;
	logic [3:0]         neg_s4;
	logic [3:0][MW-1:0] mag_s4;
	logic [NW-1:0]      nsq_s4;

	always_ff @(posedge clk) begin
		inv_s4 <= inv_s3;
		neg_s4 <= neg_s3;
		mag_s4 <= mag_s3;
		nsq_s4 <= NW'(sq_s3[0]) + NW'(sq_s3[1]) + NW'(sq_s3[2]) + NW'(sq_s3[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// ---------------------------------------------------------------
	// Norm: floor(sqrt(N)), one bit per stage; magnitudes ride along
	// ---------------------------------------------------------------
	logic               sq_vld;
	logic [RW-1:0]      norm;
	logic [SW-1:0]      sq_side;
	logic [3:0][MW-1:0] sq_mag;
	div_side_t          dv_in_side;

	dcmq_sqrt #(
		.NW (NW),
		.SW (SW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.rad      (nsq_s4),
		.in_side  ({inv_s4, neg_s4, mag_s4}),
		.out_vld  (sq_vld),
		.root     (norm),
		.out_side (sq_side)
	);

	assign sq_mag         = sq_side[4*MW-1:0];
	assign dv_in_side.neg = sq_side[4*MW+3:4*MW];
	assign dv_in_side.inv = sq_side[SW-1];

	// ---------------------------------------------------------------
	// Scale each magnitude by 2^F / norm, rounding half up
	// ---------------------------------------------------------------
	logic               dv_vld;
	logic [3:0][QW-1:0] quo;
	div_side_t          dv_side;

	dcmq_div #(
		.MW (MW),
		.F  (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.mag      (sq_mag),
		.den      (norm),
		.in_side  (dv_in_side),
		.out_vld  (dv_vld),
		.quo      (quo),
		.out_side (dv_side)
	);

	// ---------------------------------------------------------------
	// Output register: clamp to 1.0, apply sign, saturate to 16 bits
	// ---------------------------------------------------------------
	function automatic coef_t sat_comp(input logic [QW-1:0] q, input logic neg);
		logic [32:0] m;
		logic [32:0] mn;
		coef_t       r;
		m = 33'(q);
		if (m > (33'd1 << FRAC_BITS)) begin
			m = 33'd1 << FRAC_BITS;
		end
		mn = 33'd0 - m;
		if (neg) begin
			r = (m > 33'd32768) ? coef_t'(16'h8000) : coef_t'(mn[15:0]);
		end else begin
			r = (m > 33'd32767) ? coef_t'(16'h7FFF) : coef_t'(m[15:0]);
		end
		return r;
	endfunction

	logic  done_q;
	logic  inv_q;
	coef_t qx_q;
	coef_t qy_q;
	coef_t qz_q;
	coef_t qw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld;
		end
	end

	// Drop the components to zero when no estimate is positive
	always_ff @(posedge clk) begin
		inv_q <= dv_side.inv;
		qx_q  <= dv_side.inv ? '0 : sat_comp(quo[0], dv_side.neg[0]);
		qy_q  <= dv_side.inv ? '0 : sat_comp(quo[1], dv_side.neg[1]);
		qz_q  <= dv_side.inv ? '0 : sat_comp(quo[2], dv_side.neg[2]);
		qw_q  <= dv_side.inv ? '0 : sat_comp(quo[3], dv_side.neg[3]);
	end

	assign done    = done_q;
	assign invalid = inv_q;
	assign qx      = qx_q;
	assign qy      = qy_q;
	assign qz      = qz_q;
	assign qw      = qw_q;

endmodule

[src/dcmq_chk.sv]
`timescale 1ns / 1ps

module dcmq_chk #(
	parameter int FRAC_BITS = 14
) (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input dcmq_pkg::coef_t c00,
	input dcmq_pkg::coef_t c01,
	input dcmq_pkg::coef_t c02,
	input dcmq_pkg::coef_t c10,
	input dcmq_pkg::coef_t c11,
	input dcmq_pkg::coef_t c12,
	input dcmq_pkg::coef_t c20,
	input dcmq_pkg::coef_t c21,
	input dcmq_pkg::coef_t c22,
	input logic            done,
	input dcmq_pkg::coef_t qx,
	input dcmq_pkg::coef_t qy,
	input dcmq_pkg::coef_t qz,
	input dcmq_pkg::coef_t qw,
	input logic            invalid
);
	import dcmq_pkg::*;

	localparam int LIM = (FRAC_BITS > 14) ? 32767 : (1 << FRAC_BITS);

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && invalid |-> qx == 0 && qy == 0 && qz == 0 && qw == 0)
		else $error("flagged result carries nonzero components");

	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !invalid |-> qx != 0 || qy != 0 || qz != 0 || qw != 0)
		else $error("unflagged result is all zero");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> int'(qx) <= LIM && int'(qx) >= -LIM - 1 &&
		int'(qy) <= LIM && int'(qy) >= -LIM - 1 &&
		int'(qz) <= LIM && int'(qz) >= -LIM - 1 &&
		int'(qw) <= LIM && int'(qw) >= -LIM - 1)
		else $error("component beyond unit magnitude");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("transfer refused");

endmodule

bind dcm_to_quaternion dcmq_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (.*);
